// File: rtl/skt_pkg.sv
// Shared types and codes for the sorted key table and its cells.
package skt_pkg;

    localparam int KEY_W  = 64;
    localparam int WORD_W = 32;

    localparam logic [1:0] OP_LOOKUP     = 2'd0;
    localparam logic [1:0] OP_REGISTER   = 2'd1;
    localparam logic [1:0] OP_UNREGISTER = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_DUPLICATE = 2'd1;
    localparam logic [1:0] STAT_ABSENT    = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [WORD_W-1:0] handler;
        logic [WORD_W-1:0] context_word;
    } skt_entry_t;

    typedef struct packed {
        logic ins;
        logic del;
    } skt_ctl_t;

endpackage

// File: rtl/sorted_key_table.sv
// Sorted key table: a row of cells kept in ascending 128-bit key order.
// An accepted request enters ST_UPDATE, which waits while an unread result
// is stalled; in_stall holds off new requests until it ends. Cells compare
// at acceptance; the row shifts up or down in one step as the result registers.
// Reset clears the entry count and the output valid; stored entries stay
// undefined and need no clearing pass.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CNT_W = $clog2(CAPACITY + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [KEY_W-1:0]  key_high,
    input  logic [KEY_W-1:0]  key_low,
    input  logic [WORD_W-1:0] handler_value,
    input  logic [WORD_W-1:0] context_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic              found,
    output logic [CNT_W-1:0]  position,
    output logic [WORD_W-1:0] handler_out,
    output logic [WORD_W-1:0] context_out,
    output logic [CNT_W-1:0]  entry_total
);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t            state_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              found_reg;
    logic [CNT_W-1:0]  position_reg;
    logic [CNT_W-1:0]  position_next;
    logic [WORD_W-1:0] handler_reg;
    logic [WORD_W-1:0] handler_next;
    logic [WORD_W-1:0] context_reg;
    logic [WORD_W-1:0] context_next;
    logic [1:0]        req_op_reg;
    skt_entry_t        req_entry_reg;

    logic              accept;
    logic              done;
    logic              hit;
    logic              full;
    skt_ctl_t          ctl;

    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] below_flags;
    logic [CAPACITY-1:0] equal_flags;
    logic [CAPACITY:0]   below_ext;
    logic [CAPACITY:0]   prev_ext;
    skt_entry_t          cell_entry [CAPACITY];

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg == ST_UPDATE);
    assign done     = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);

    assign below_ext = {1'b0, below_flags};
    assign prev_ext  = {below_flags, 1'b1};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            skt_entry_t prev_entry;
            skt_entry_t next_entry;

            assign occ[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign prev_entry = cell_entry[gi];
            end
            else
            begin : g_mid
                assign prev_entry = cell_entry[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_entry = cell_entry[gi];
            end
            else
            begin : g_inner
                assign next_entry = cell_entry[gi+1];
            end

            skt_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .capture      (accept),
                .ctl          (ctl),
                .cmp_key_high (key_high),
                .cmp_key_low  (key_low),
                .occupied     (occ[gi]),
                .prev_below   (prev_ext[gi]),
                .new_entry    (req_entry_reg),
                .prev_entry   (prev_entry),
                .next_entry   (next_entry),
                .cell_entry   (cell_entry[gi]),
                .below        (below_flags[gi]),
                .equal        (equal_flags[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit           = |equal_flags;
        position_next = '0;
        handler_next  = '0;
        context_next  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (below_ext[i] && !below_ext[i+1])
            begin
                position_next = position_next | CNT_W'(i + 1);
            end
            if (equal_flags[i])
            begin
                handler_next = handler_next | cell_entry[i].handler;
                context_next = context_next | cell_entry[i].context_word;
            end
        end
    end

    assign full = (count_reg >= CNT_W'(CAPACITY));

    always_comb
    begin
        ctl.ins = 1'b0;
        ctl.del = 1'b0;
        case (req_op_reg)
            OP_REGISTER:
            begin
                status_next = hit ? STAT_DUPLICATE : (full ? STAT_FULL : STAT_OK);
                ctl.ins     = done && !hit && !full;
            end
            OP_UNREGISTER:
            begin
                status_next = hit ? STAT_OK : STAT_ABSENT;
                ctl.del     = done && hit;
            end
            default:
            begin
                status_next = hit ? STAT_OK : STAT_ABSENT;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg                 <= op;
            req_entry_reg.key_high     <= key_high;
            req_entry_reg.key_low      <= key_low;
            req_entry_reg.handler      <= handler_value;
            req_entry_reg.context_word <= context_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            status_reg    <= STAT_OK;
            found_reg     <= 1'b0;
            position_reg  <= '0;
            handler_reg   <= '0;
            context_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_UPDATE:
                begin
                    if (done)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        count_reg     <= count_next;
                        status_reg    <= status_next;
                        found_reg     <= hit;
                        position_reg  <= position_next;
                        handler_reg   <= handler_next;
                        context_reg   <= context_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign handler_out = handler_reg;
    assign context_out = context_reg;
    assign entry_total = count_reg;

`ifndef NO_ASSERTIONS
    a_single_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins && ctl.del))
        else $error("insert and delete asserted together");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $onehot0(equal_flags))
        else $error("more than one cell matches the key");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(done))
        else $error("entry count changed outside an update");
`endif

endmodule

// File: rtl/skt_cell.sv
// One table slot: holds an entry, compares it against a request key, shifts with neighbors.
module skt_cell
    import skt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              capture,
    input  skt_ctl_t          ctl,
    input  logic [KEY_W-1:0]  cmp_key_high,
    input  logic [KEY_W-1:0]  cmp_key_low,
    input  logic              occupied,
    input  logic              prev_below,
    input  skt_entry_t        new_entry,
    input  skt_entry_t        prev_entry,
    input  skt_entry_t        next_entry,
    output skt_entry_t        cell_entry,
    output logic              below,
    output logic              equal
);

    skt_entry_t entry_reg;
    skt_entry_t entry_next;
    logic       below_reg;
    logic       below_next;
    logic       equal_reg;
    logic       equal_next;

    always_comb
    begin
        below_next = occupied &&
            ({entry_reg.key_high, entry_reg.key_low} < {cmp_key_high, cmp_key_low});
        equal_next = occupied &&
            ({entry_reg.key_high, entry_reg.key_low} == {cmp_key_high, cmp_key_low});
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && !below_reg)
        begin
            entry_next = prev_below ? new_entry : prev_entry;
        end
        else if (ctl.del && !below_reg)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_reg <= 1'b0;
            equal_reg <= 1'b0;
        end
        else if (capture)
        begin
            below_reg <= below_next;
            equal_reg <= equal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign cell_entry = entry_reg;
    assign below      = below_reg;
    assign equal      = equal_reg;

endmodule

// File: dv/sorted_key_table_checker.sv
// Checker for the sorted key table: predicts each reply and compares it with the block.
module sorted_key_table_checker
    import skt_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CNT_W = $clog2(CAPACITY + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        op,
    input  logic [KEY_W-1:0]  key_high,
    input  logic [KEY_W-1:0]  key_low,
    input  logic [WORD_W-1:0] handler_value,
    input  logic [WORD_W-1:0] context_value,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [1:0]        status,
    input  logic              found,
    input  logic [CNT_W-1:0]  position,
    input  logic [WORD_W-1:0] handler_out,
    input  logic [WORD_W-1:0] context_out,
    input  logic [CNT_W-1:0]  entry_total,
    output int                fail_count,
    output int                results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        status;
        logic              found;
        logic [CNT_W-1:0]  position;
        logic [WORD_W-1:0] handler_word;
        logic [WORD_W-1:0] context_word;
        logic [CNT_W-1:0]  entry_total;
    } table_reply_t;

    logic [KEY_W-1:0]  stored_key_high [CAPACITY];
    logic [KEY_W-1:0]  stored_key_low  [CAPACITY];
    logic [WORD_W-1:0] stored_handler  [CAPACITY];
    logic [WORD_W-1:0] stored_context  [CAPACITY];
    int                stored_count;

    table_reply_t      pending_replies [$];
    table_reply_t      oldest_reply;

    initial fail_count = 0;

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] wanted);
        if (fail_count < 40)
            $display("%0t ns: %s: got %0h, want %0h", $time, what, got, wanted);
        fail_count++;
    endtask

    function automatic table_reply_t apply_command(input logic [1:0] cmd,
                                                   input logic [KEY_W-1:0] kh,
                                                   input logic [KEY_W-1:0] kl,
                                                   input logic [WORD_W-1:0] hv,
                                                   input logic [WORD_W-1:0] cv);
        table_reply_t reply;
        int           count;
        int           slot;
        logic         hit;

        count = stored_count;
        slot  = 0;
        while (slot < count && {stored_key_high[slot], stored_key_low[slot]} < {kh, kl})
            slot++;
        hit = slot < count && stored_key_high[slot] == kh && stored_key_low[slot] == kl;

        reply = '0;
        reply.found    = hit;
        reply.position = CNT_W'(slot);
        if (hit)
        begin
            reply.handler_word = stored_handler[slot];
            reply.context_word = stored_context[slot];
        end

        case (cmd)
            OP_REGISTER:
            begin
                if (hit)
                    reply.status = STAT_DUPLICATE;
                else if (count >= CAPACITY)
                    reply.status = STAT_FULL;
                else
                begin
                    for (int i = count; i > slot; i--)
                    begin
                        stored_key_high[i] = stored_key_high[i - 1];
                        stored_key_low[i]  = stored_key_low[i - 1];
                        stored_handler[i]  = stored_handler[i - 1];
                        stored_context[i]  = stored_context[i - 1];
                    end
                    stored_key_high[slot] = kh;
                    stored_key_low[slot]  = kl;
                    stored_handler[slot]  = hv;
                    stored_context[slot]  = cv;
                    count++;
                    reply.status = STAT_OK;
                end
            end
            OP_UNREGISTER:
            begin
                if (hit)
                begin
                    for (int i = slot; i + 1 < count; i++)
                    begin
                        stored_key_high[i] = stored_key_high[i + 1];
                        stored_key_low[i]  = stored_key_low[i + 1];
                        stored_handler[i]  = stored_handler[i + 1];
                        stored_context[i]  = stored_context[i + 1];
                    end
                    count--;
                    reply.status = STAT_OK;
                end
                else
                    reply.status = STAT_ABSENT;
            end
            default:
                reply.status = hit ? STAT_OK : STAT_ABSENT;
        endcase

        stored_count      = count;
        reply.entry_total = CNT_W'(count);
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_count = 0;
            pending_replies.delete();
            results_due <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                    report_mismatch("reply with no request outstanding", status, '0);
                else
                begin
                    oldest_reply = pending_replies.pop_front();
                    if (status !== oldest_reply.status)
                        report_mismatch("status", status, oldest_reply.status);
                    if (found !== oldest_reply.found)
                        report_mismatch("found", found, oldest_reply.found);
                    if (position !== oldest_reply.position)
                        report_mismatch("position", position, oldest_reply.position);
                    if (handler_out !== oldest_reply.handler_word)
                        report_mismatch("handler_out", handler_out, oldest_reply.handler_word);
                    if (context_out !== oldest_reply.context_word)
                        report_mismatch("context_out", context_out, oldest_reply.context_word);
                    if (entry_total !== oldest_reply.entry_total)
                        report_mismatch("entry_total", entry_total, oldest_reply.entry_total);
                end
            end
            if (in_valid && !in_stall)
                pending_replies.push_back(apply_command(op, key_high, key_low,
                                                        handler_value, context_value));
            results_due <= pending_replies.size();
        end
    end

endmodule

// File: dv/tb_sorted_key_table.sv
// Testbench top for the sorted key table: clock, reset, request traffic and verdict.
module tb_sorted_key_table;
    import skt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 16;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 700;
    localparam int POOL_SIZE    = 24;
    localparam int LONG_HOLD    = 120;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        op;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [WORD_W-1:0] handler_value;
    logic [WORD_W-1:0] context_value;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic              found;
    logic [CNT_W-1:0]  position;
    logic [WORD_W-1:0] handler_out;
    logic [WORD_W-1:0] context_out;
    logic [CNT_W-1:0]  entry_total;

    int fail_count;
    int results_due;
    int send_idle_pct = 12;
    int recv_idle_pct = 83;
    int hold_requests = 0;
    int holds_served;
    int hold_left;
    int cycle_count;

    logic [KEY_W-1:0] pool_high [POOL_SIZE];
    logic [KEY_W-1:0] pool_low  [POOL_SIZE];

    sorted_key_table #(.CAPACITY(CAPACITY)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .key_high      (key_high),
        .key_low       (key_low),
        .handler_value (handler_value),
        .context_value (context_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .position      (position),
        .handler_out   (handler_out),
        .context_out   (context_out),
        .entry_total   (entry_total)
    );

    sorted_key_table_checker #(.CAPACITY(CAPACITY)) reply_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .key_high      (key_high),
        .key_low       (key_low),
        .handler_value (handler_value),
        .context_value (context_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .position      (position),
        .handler_out   (handler_out),
        .context_out   (context_out),
        .entry_total   (entry_total),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [KEY_W-1:0] random_key_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [KEY_W-1:0] kh,
                                input logic [KEY_W-1:0] kl, input logic [WORD_W-1:0] hv,
                                input logic [WORD_W-1:0] cv);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        op            = cmd;
        key_high      = kh;
        key_low       = kl;
        handler_value = hv;
        context_value = cv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_pool_request(input logic [1:0] cmd, input int idx);
        send_request(cmd, pool_high[idx], pool_low[idx], $urandom, $urandom);
    endtask

    // hold off the reply side on request, otherwise stall at the current rate
    initial
    begin
        out_stall    = 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] kh;
        logic [KEY_W-1:0] kl;
        logic [KEY_W-1:0] shared_high;
        logic [1:0]       cmd;
        int               pick;
        int               idx;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_LOOKUP;
        key_high      = '0;
        key_low       = '0;
        handler_value = '0;
        context_value = '0;

        pool_high[0] = '0;
        pool_low[0]  = '0;
        pool_high[1] = '1;
        pool_low[1]  = '1;
        for (int i = 2; i < 16; i++)
        begin
            pool_high[i] = 64'h8000_0000_0000_0000;
            pool_low[i]  = random_key_word();
        end
        shared_high = random_key_word();
        for (int i = 16; i < POOL_SIZE; i++)
        begin
            pool_high[i] = (i < 20) ? shared_high : random_key_word();
            pool_low[i]  = random_key_word();
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        send_pool_request(OP_LOOKUP, 0);
        send_pool_request(OP_UNREGISTER, 1);
        send_request(OP_REGISTER, pool_high[0], pool_low[0], '1, '1);
        send_request(OP_REGISTER, pool_high[1], pool_low[1], '0, '0);
        send_pool_request(OP_REGISTER, 1);
        send_pool_request(OP_UNDEFINED, 0);
        send_pool_request(OP_LOOKUP, 1);
        for (int i = 2; i < 16; i++)
            send_pool_request(OP_REGISTER, i);
        send_pool_request(OP_REGISTER, 16);
        send_pool_request(OP_REGISTER, 1);
        send_pool_request(OP_UNREGISTER, 0);
        send_pool_request(OP_UNREGISTER, 20);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 12;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_requests++;
            end

            // alternate fill and drain bias so the table swings between empty and full
            pick = $urandom_range(0, 99);
            if ((n / 40) % 2 == 0)
                cmd = (pick < 55) ? OP_REGISTER : (pick < 70) ? OP_UNREGISTER :
                      (pick < 95) ? OP_LOOKUP : OP_UNDEFINED;
            else
                cmd = (pick < 20) ? OP_REGISTER : (pick < 65) ? OP_UNREGISTER :
                      (pick < 95) ? OP_LOOKUP : OP_UNDEFINED;

            if ($urandom_range(0, 99) < 85)
            begin
                idx = $urandom_range(0, POOL_SIZE - 1);
                kh  = pool_high[idx];
                kl  = pool_low[idx];
            end
            else
            begin
                kh = random_key_word();
                kl = random_key_word();
            end
            send_request(cmd, kh, kl, $urandom, $urandom);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
